// ===== rtl/core/htfd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_pkg
// Shared types, constants and the CRC-8 step of the frame decoder.
// ----------------------------------------------------------------------------
package htfd_pkg;

   localparam logic [7:0] CRC_INIT = 8'hFF;
   localparam logic [7:0] CRC_POLY = 8'h31;

   // 17500 / 65536 scales a raw temperature word to centidegrees
   localparam logic [14:0] TEMP_SCALE = 15'd17500;
   // 10000 / 65536 scales a raw humidity word to centipercent
   localparam logic [13:0] HUM_SCALE  = 14'd10000;
   localparam logic signed [16:0] TEMP_BIAS = 17'sd4500;

   // byte slot inside a six-byte frame
   typedef enum logic [2:0] {
      POS_TEMP_HI  = 3'd0,
      POS_TEMP_LO  = 3'd1,
      POS_TEMP_CRC = 3'd2,
      POS_HUM_HI   = 3'd3,
      POS_HUM_LO   = 3'd4,
      POS_HUM_CRC  = 3'd5
   } pos_type;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
      logic       frame_start;
   } beat_slot_type;

   typedef struct packed {
      logic               crc_error;
      logic signed [15:0] temperature_centi_c;
      logic [13:0]        humidity_centi_pct;
   } result_type;

   typedef struct packed {
      logic       valid;
      result_type data;
   } result_slot_type;

   // one byte through the crc, msb first, unrolled
   function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
      end
      return c;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/htfd_channels.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd channels
// Valid/ready channel interfaces for request, response and register write.
// ----------------------------------------------------------------------------
interface htfd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;
   logic       frame_start;

   modport source (output valid, output rx_byte, output frame_start, input ready);
   modport sink   (input valid, input rx_byte, input frame_start, output ready);
endinterface

interface htfd_rsp_if;
   logic               valid;
   logic               ready;
   logic               crc_error;
   logic signed [15:0] temperature_centi_c;
   logic [13:0]        humidity_centi_pct;

   modport source (output valid, output crc_error, output temperature_centi_c,
                   output humidity_centi_pct, input ready);
   modport sink   (input valid, input crc_error, input temperature_centi_c,
                   input humidity_centi_pct, output ready);
endinterface

interface htfd_csr_if;
   logic              valid;
   logic              ready;
   logic signed [9:0] temp_offset_decidegrees;

   modport source (output valid, output temp_offset_decidegrees, input ready);
   modport sink   (input valid, input temp_offset_decidegrees, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/htfd_in_reg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_in_reg
// Input register holding one received beat until the frame core takes it.
// ----------------------------------------------------------------------------
module htfd_in_reg
   import htfd_pkg::*;
(
   input  wire logic   clock,
   input  wire logic   reset,
   htfd_req_if.sink    req_chan,
   input  wire logic   consume,
   output beat_slot_type in_slot
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff;
   logic       start_ff;
   logic       accept;

   assign req_chan.ready = !valid_ff || consume;
   assign accept         = req_chan.valid && req_chan.ready;
   assign valid_in       = accept || (valid_ff && !consume);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff  <= req_chan.rx_byte;
         start_ff <= req_chan.frame_start;
      end
   end

   assign in_slot = '{valid: valid_ff, rx_byte: byte_ff, frame_start: start_ff};

   // a held beat stays put until the core takes it
   a_hold_beat: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !consume) |=> (valid_ff && $stable(byte_ff) && $stable(start_ff)))
      else $error("held beat changed before consume");

endmodule
`default_nettype wire

// ===== rtl/core/htfd_frame_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// htfd_frame_core
// Frame position tracking, crc checks and fixed-point scaling per byte.
// ----------------------------------------------------------------------------
module htfd_frame_core
   import htfd_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire beat_slot_type      in_slot,
   input  wire logic signed [9:0]  temp_offset,
   input  wire logic               out_free,
   output logic                    consume,
   output result_slot_type         out_slot
);

   pos_type     pos_ff, pos_in, pos_eff;
   logic [7:0]  crc_ff, crc_in;
   logic        tbad_ff, tbad_in;
   logic [7:0]  temp_hi_ff, temp_hi_in;
   logic [14:0] temp_scaled_ff, temp_scaled_in;
   logic [7:0]  hum_hi_ff, hum_hi_in;
   logic [13:0] hum_scaled_ff, hum_scaled_in;

   logic [7:0]  seed;
   logic [7:0]  crc_step;
   logic        produces;
   logic [30:0] temp_prod;
   logic [29:0] hum_prod;
   logic        bad;
   logic signed [16:0] off_ext;
   logic signed [16:0] temp_sum;

   always_comb begin
      // a start mark or an impossible position restarts the frame
      if (in_slot.frame_start || (pos_ff > POS_HUM_CRC)) begin
         pos_eff = POS_TEMP_HI;
      end else begin
         pos_eff = pos_ff;
      end

      produces = (pos_eff == POS_HUM_CRC);
      consume  = in_slot.valid && (!produces || out_free);

      seed     = ((pos_eff == POS_TEMP_HI) || (pos_eff == POS_HUM_HI)) ? CRC_INIT : crc_ff;
      crc_step = crc8_byte(seed, in_slot.rx_byte);

      temp_prod = 31'(TEMP_SCALE) * 31'({temp_hi_ff, in_slot.rx_byte});
      hum_prod  = 30'(HUM_SCALE) * 30'({hum_hi_ff, in_slot.rx_byte});

      pos_in         = pos_ff;
      crc_in         = crc_ff;
      tbad_in        = tbad_ff;
      temp_hi_in     = temp_hi_ff;
      temp_scaled_in = temp_scaled_ff;
      hum_hi_in      = hum_hi_ff;
      hum_scaled_in  = hum_scaled_ff;

      if (consume) begin
         pos_in = produces ? POS_TEMP_HI : pos_type'(pos_eff + 3'd1);
         unique case (pos_eff)
            POS_TEMP_HI: begin
               crc_in     = crc_step;
               temp_hi_in = in_slot.rx_byte;
            end
            POS_TEMP_LO: begin
               crc_in         = crc_step;
               temp_scaled_in = temp_prod[30:16];
            end
            POS_TEMP_CRC: begin
               tbad_in = (crc_ff != in_slot.rx_byte);
               crc_in  = CRC_INIT;
            end
            POS_HUM_HI: begin
               crc_in    = crc_step;
               hum_hi_in = in_slot.rx_byte;
            end
            POS_HUM_LO: begin
               crc_in        = crc_step;
               hum_scaled_in = hum_prod[29:16];
            end
            POS_HUM_CRC: begin
               crc_in = CRC_INIT;
            end
            default: begin
               crc_in = CRC_INIT;
            end
         endcase
      end

      // temperature: scaled - 45.00 degrees + offset * 10
      off_ext  = 17'(temp_offset);
      temp_sum = $signed({2'b00, temp_scaled_ff}) - TEMP_BIAS
               + (off_ext <<< 3) + (off_ext <<< 1);
      bad      = tbad_ff || (crc_ff != in_slot.rx_byte);

      out_slot.valid                    = consume && produces;
      out_slot.data.crc_error           = bad;
      out_slot.data.temperature_centi_c = bad ? 16'sd0 : temp_sum[15:0];
      out_slot.data.humidity_centi_pct  = bad ? 14'd0 : hum_scaled_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= POS_TEMP_HI;
         crc_ff  <= CRC_INIT;
         tbad_ff <= 1'b0;
      end else begin
         pos_ff  <= pos_in;
         crc_ff  <= crc_in;
         tbad_ff <= tbad_in;
      end
   end

   always_ff @(posedge clock) begin
      temp_hi_ff     <= temp_hi_in;
      temp_scaled_ff <= temp_scaled_in;
      hum_hi_ff      <= hum_hi_in;
      hum_scaled_ff  <= hum_scaled_in;
   end

   a_wrap_after_result: assert property (@(posedge clock) disable iff (reset)
      (consume && produces) |=> (pos_ff == POS_TEMP_HI))
      else $error("position did not wrap after the last byte");

   a_start_realigns: assert property (@(posedge clock) disable iff (reset)
      (consume && in_slot.frame_start) |=> (pos_ff == POS_TEMP_LO))
      else $error("start mark did not realign the frame");

   a_no_stall_midframe: assert property (@(posedge clock) disable iff (reset)
      (in_slot.valid && !produces) |-> consume)
      else $error("non-final byte stalled");

endmodule
`default_nettype wire

// ===== rtl/core/humidity_temp_frame_decoder.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// humidity_temp_frame_decoder
// Decodes six-byte temperature/humidity sensor frames with crc-8 checks.
// ----------------------------------------------------------------------------
//  channel    dir   beat contents
//  req_chan   in    rx_byte[7:0], frame_start
//  rsp_chan   out   crc_error, temperature_centi_c[15:0] s, humidity_centi_pct[13:0]
//  csr_chan   in    temp_offset_decidegrees[9:0] s
//
//  one byte per cycle sustained while each response is taken; a byte is held in the input
//  register, and the result of the sixth byte goes straight into the output register
//  synchronous active-high reset clears position, crc, valids and the offset
//  a stalled response holds only the sixth byte of the next frame in the input
//  register; the five bytes before it still flow
// ----------------------------------------------------------------------------
module humidity_temp_frame_decoder
   import htfd_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   htfd_req_if.sink   req_chan,
   htfd_rsp_if.source rsp_chan,
   htfd_csr_if.sink   csr_chan
);

   beat_slot_type     in_slot;
   result_slot_type   core_slot;
   logic              consume;
   logic              out_free;

   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_data_ff;
   logic signed [9:0] offset_ff;

   // offset register, always ready; write it only while idle, the block does not enforce this
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= 10'sd0;
      end else if (csr_chan.valid) begin
         offset_ff <= csr_chan.temp_offset_decidegrees;
      end
   end

   // input register stage
   htfd_in_reg u_in_reg (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .consume  (consume),
      .in_slot  (in_slot)
   );

   // per-byte frame logic
   htfd_frame_core u_core (
      .clock       (clock),
      .reset       (reset),
      .in_slot     (in_slot),
      .temp_offset (offset_ff),
      .out_free    (out_free),
      .consume     (consume),
      .out_slot    (core_slot)
   );

   // result register: free when empty or being drained this cycle
   assign out_free     = !rsp_valid_ff || rsp_chan.ready;
   assign rsp_valid_in = core_slot.valid || (rsp_valid_ff && !rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (core_slot.valid) begin
         rsp_data_ff <= core_slot.data;
      end
   end

   assign rsp_chan.valid               = rsp_valid_ff;
   assign rsp_chan.crc_error           = rsp_data_ff.crc_error;
   assign rsp_chan.temperature_centi_c = rsp_data_ff.temperature_centi_c;
   assign rsp_chan.humidity_centi_pct  = rsp_data_ff.humidity_centi_pct;

   // a new result never lands on one that has not been taken
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (core_slot.valid && rsp_valid_ff) |-> rsp_chan.ready)
      else $error("result overwritten before it was taken");

endmodule
`default_nettype wire
